[src/pts_pkg.sv]
// package for the periodic task scheduler
// types and status codes used by the core; no dependencies
package pts_pkg;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] ST_FIRED    = 2'd0;
    localparam logic [1:0] ST_ADDED    = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  task_tag;
        logic [15:0] period;
    } in_item_t;

    typedef struct packed {
        logic [7:0] result_tag;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    // one stored task: deadline, period, tag
    typedef struct packed {
        logic [31:0] deadline;
        logic [15:0] period;
        logic [7:0]  tag;
    } entry_t;

endpackage

[src/pts_ram.sv]
// generic single-port-write, one-read synchronous ram with registered read
// no dependencies
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/periodic_task_scheduler_core.sv]
// periodic task scheduler top level: control sequencer around the task ram
// depends on pts_pkg and pts_ram
// sequence: an add answers in the cycle after acceptance; a tick scans the table
//   once per fired task, then reads the winner and writes back its next deadline;
//   a final scan and the closing S_OUT state follow, and output back-pressure can
//   stall S_FIRE_WR and S_OUT
// throughput: one item at a time; the next is taken once the last result is out
// reset: synchronous active low, clears time and task count; ram is not cleared
module periodic_task_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pts_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pts_pkg::out_item_t m_data
);
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int EW = $bits(pts_pkg::entry_t);
    localparam int FW = $clog2(pts_pkg::MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_FIRE_RD, S_FIRE_WR, S_OUT
    } state_t;

    state_t                state_reg;
    logic [31:0]           time_reg;
    logic [CW-1:0]         count_reg;
    logic [AW:0]           rd_idx_reg;    // scan address issued
    logic                  rd_vld_reg;    // ram data valid this cycle
    logic [AW-1:0]         rd_addr_q_reg; // address of ram data
    logic                  found_reg;
    logic [AW-1:0]         best_reg;
    logic [31:0]           best_age_reg;
    logic [MAX_TASKS-1:0]  fired_reg;
    logic [FW-1:0]         nfired_reg;
    logic                  out_pend_reg;  // a fired result held for output
    logic [7:0]            pend_tag_reg;  // held fired tag, sent once the next one is known
    logic                  is_tick_reg;
    pts_pkg::out_item_t    m_data_reg;
    logic                  m_valid_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    pts_pkg::entry_t       ram_wdata;
    logic [AW-1:0]         ram_raddr;
    pts_pkg::entry_t       ram_rdata;

    logic                  in_take;
    logic                  out_free;
    logic                  scan_more;
    logic                  fire_go;
    logic                  load_out;

    pts_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [31:0] age;
    logic        cand;
    assign age  = time_reg - ram_rdata.deadline;
    assign cand = rd_vld_reg && !fired_reg[rd_addr_q_reg] && !age[31];

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign in_take   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_more = rd_idx_reg < (AW+1)'(count_reg);
    // a pending fired item needs the output register before the next is held
    assign fire_go   = !out_pend_reg || out_free;
    assign load_out  = ((state_reg == S_IDLE) && in_take
                        && (s_data.opcode == pts_pkg::OP_ADD))
                     || (((state_reg == S_FIRE_WR) || (state_reg == S_OUT))
                        && out_pend_reg && out_free);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = best_reg;
        ram_wdata = ram_rdata;
        ram_raddr = rd_idx_reg[AW-1:0];
        if (state_reg == S_IDLE) begin
            ram_waddr = count_reg[AW-1:0];
            ram_wdata.deadline = time_reg + {16'd0, s_data.period};
            ram_wdata.period   = s_data.period;
            ram_wdata.tag      = s_data.task_tag;
            ram_we = in_take && (s_data.opcode == pts_pkg::OP_ADD)
                     && (count_reg < CW'(MAX_TASKS));
        end else if (state_reg == S_FIRE_RD) begin
            ram_raddr = best_reg;
        end else if (state_reg == S_FIRE_WR) begin
            // keep the winner on the read port while waiting for the output
            ram_raddr = best_reg;
            ram_wdata.deadline = ram_rdata.deadline + {16'd0, ram_rdata.period};
            ram_we = fire_go;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            time_reg     <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            out_pend_reg <= 1'b0;
            is_tick_reg  <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            rd_vld_reg    <= (state_reg == S_SCAN) && scan_more;
            rd_addr_q_reg <= rd_idx_reg[AW-1:0];
            unique case (state_reg)
                S_IDLE: begin
                    if (in_take) begin
                        if (s_data.opcode == pts_pkg::OP_ADD) begin
                            m_data_reg.result_tag <= s_data.task_tag;
                            m_data_reg.last       <= 1'b1;
                            is_tick_reg           <= 1'b0;
                            if (count_reg < CW'(MAX_TASKS)) begin
                                m_data_reg.status <= pts_pkg::ST_ADDED;
                                count_reg         <= count_reg + 1'b1;
                            end else begin
                                m_data_reg.status <= pts_pkg::ST_REJECTED;
                            end
                        end else begin
                            time_reg     <= time_reg + 32'd1;
                            fired_reg    <= '0;
                            nfired_reg   <= '0;
                            rd_idx_reg   <= '0;
                            found_reg    <= 1'b0;
                            best_age_reg <= '0;
                            is_tick_reg  <= 1'b1;
                            state_reg    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // issue reads one per cycle, compare as data returns
                    if (scan_more) begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (cand && (!found_reg || age > best_age_reg)) begin
                        found_reg    <= 1'b1;
                        best_reg     <= rd_addr_q_reg;
                        best_age_reg <= age;
                    end
                    if (!rd_vld_reg && !scan_more) begin
                        // scan done: decide using the final best
                        if (found_reg && nfired_reg < FW'(pts_pkg::MAX_RESULTS)) begin
                            state_reg <= S_FIRE_RD;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_FIRE_RD: begin
                    state_reg <= S_FIRE_WR;
                end
                S_FIRE_WR: begin
                    if (fire_go) begin
                        if (out_pend_reg) begin
                            m_data_reg.result_tag <= pend_tag_reg;
                            m_data_reg.status     <= pts_pkg::ST_FIRED;
                            m_data_reg.last       <= 1'b0;
                        end
                        out_pend_reg        <= 1'b1;
                        pend_tag_reg        <= ram_rdata.tag;
                        fired_reg[best_reg] <= 1'b1;
                        nfired_reg          <= nfired_reg + 1'b1;
                        rd_idx_reg          <= '0;
                        found_reg           <= 1'b0;
                        best_age_reg        <= '0;
                        state_reg           <= S_SCAN;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        if (out_pend_reg) begin
                            m_data_reg.result_tag <= pend_tag_reg;
                            m_data_reg.status     <= pts_pkg::ST_FIRED;
                            m_data_reg.last       <= 1'b1;
                        end
                        out_pend_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item taken while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CW'(MAX_TASKS)))
        else $error("task count over capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == pts_pkg::ST_FIRED) |-> is_tick_reg)
        else $error("fired result outside a tick");
endmodule
